/* rtl/ptm_pkg.sv */
package ptm_pkg;

    localparam int NODES_DEF   = 8;
    localparam int HORIZON_DEF = 64;

    // Stream payload widths
    localparam int IN_W   = 8;
    localparam int NV_W   = 8;
    localparam int OUT_W  = 16;
    localparam int OUT_PAD = OUT_W - NV_W - 1;

    // Per-node config field widths
    localparam int KIND_W  = 4;
    localparam int OPIDX_W = 3;
    localparam int BOUND_W = 8;
    localparam logic [BOUND_W-1:0] INF_CODE = 8'd255;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_COUNT     = 3'd0,
        REG_NODE_KINDS     = 3'd1,
        REG_LEFT_OPERANDS  = 3'd2,
        REG_RIGHT_OPERANDS = 3'd3,
        REG_LOWER_BOUNDS   = 3'd4,
        REG_UPPER_BOUNDS   = 3'd5
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        K_PROP    = 4'd0,
        K_AND     = 4'd1,
        K_OR      = 4'd2,
        K_NOT     = 4'd3,
        K_IMPLIES = 4'd4,
        K_ONCE    = 4'd5,
        K_HIST    = 4'd6,
        K_SINCE   = 4'd7,
        K_HOLD    = 4'd8
    } kind_t;

endpackage

/* rtl/past_time_mtl_monitor_top.sv */
// Sequence: a tick word is taken in ST_IDLE, each configured node is processed in turn
//   in ST_RUN, and ST_FLUSH loads the result onto m_tvalid/m_tdata once the output is free.
// Ticks: a new tick is accepted only in ST_IDLE, so only one is in flight; the
//   pending-state RAM, with one read and one write port, serves one node per cycle.
// Reset: rst_n is asynchronous, active low; clears control, config and node
//   outputs, and marks every pending-state RAM entry as empty (no clearing pass).
module past_time_mtl_monitor_top #(
    parameter int NODES   = ptm_pkg::NODES_DEF,
    parameter int HORIZON = ptm_pkg::HORIZON_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptm_pkg::IN_W-1:0]        s_tdata,   // [7:0] prop_bits
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptm_pkg::OUT_W-1:0]       m_tdata,   // [0] verdict, [8:1] node_values
    // config write port
    input  logic                            cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ptm_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = HORIZON + 1;   // bitmap plus tail flag
    localparam logic [BOUND_W-1:0] HMAX = BOUND_W'(HORIZON - 1);
    localparam logic [AW-1:0] NODE_MAX = AW'(NODES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        cur_reg;       // node whose RAM word is on rdata
    logic [AW-1:0]        last_reg;      // last node of this tick
    logic [IN_W-1:0]      prop_reg;
    logic [NODES-1:0]     node_value_reg;
    logic [NODES-1:0]     node_value_next;
    logic [NODES-1:0]     entry_valid_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    // config registers
    logic [3:0]           node_count_reg;
    logic [31:0]          node_kinds_reg;
    logic [23:0]          left_operands_reg;
    logic [23:0]          right_operands_reg;
    logic [63:0]          lower_bounds_reg;
    logic [63:0]          upper_bounds_reg;

    // RAM
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [PW-1:0]        ram_rdata;
    logic [PW-1:0]        ram_wdata;

    // per-node datapath
    kind_t                kind;
    logic [OPIDX_W-1:0]   l_idx;
    logic [OPIDX_W-1:0]   r_idx;
    logic [NV_W-1:0]      nv_ext;
    logic                 l_op;
    logic                 r_op;
    logic [BOUND_W-1:0]   a_raw;
    logic [BOUND_W-1:0]   b_raw;
    logic [BOUND_W-1:0]   a_sat;
    logic [BOUND_W-1:0]   b_sat;
    logic                 b_inf;
    logic [HORIZON-1:0]   win_bits;
    logic [PW-1:0]        old_word;
    logic [HORIZON-1:0]   upd_bits;
    logic                 upd_tail;
    logic                 temporal;
    logic                 node_val;
    logic                 node_upd;
    logic [3:0]           count_clamped;
    logic                 in_fire;
    logic                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // node_count 0 means 1, above NODES means NODES
    always_comb
    begin
        if (node_count_reg == 4'd0)
        begin
            count_clamped = 4'd1;
        end
        else if (32'(node_count_reg) > NODES)
        begin
            count_clamped = 4'(NODES);
        end
        else
        begin
            count_clamped = node_count_reg;
        end
    end

    // Next node is prefetched while the current one is processed
    always_comb
    begin
        if (state_reg != ST_RUN || cur_reg == last_reg)
        begin
            ram_raddr = '0;
        end
        else
        begin
            ram_raddr = cur_reg + 1'b1;
        end
    end

    ptm_ram #(
        .WIDTH (PW),
        .DEPTH (NODES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operand and bound decode for the current node
    always_comb
    begin
        kind   = kind_t'(node_kinds_reg[KIND_W*cur_reg +: KIND_W]);
        l_idx  = left_operands_reg[OPIDX_W*cur_reg +: OPIDX_W];
        r_idx  = right_operands_reg[OPIDX_W*cur_reg +: OPIDX_W];
        nv_ext = NV_W'(node_value_reg);
        // out-of-range operand index reads the zero extension
        l_op   = nv_ext[l_idx];
        r_op   = nv_ext[r_idx];
        a_raw  = lower_bounds_reg[BOUND_W*cur_reg +: BOUND_W];
        b_raw  = upper_bounds_reg[BOUND_W*cur_reg +: BOUND_W];
        b_inf  = (b_raw == INF_CODE);
        a_sat  = (a_raw > HMAX) ? HMAX : a_raw;
        b_sat  = (b_inf || b_raw > HMAX) ? HMAX : b_raw;
    end

    // Window mask a..b; empty when a > b
    always_comb
    begin
        for (int k = 0; k < HORIZON; k++)
        begin
            win_bits[k] = (BOUND_W'(k) >= a_sat) && (BOUND_W'(k) <= b_sat);
        end
    end

    // Pending-set update; never-written entries read as empty
    always_comb
    begin
        old_word = entry_valid_reg[cur_reg] ? ram_rdata : '0;
        upd_bits = old_word[HORIZON-1:0];
        upd_tail = old_word[HORIZON];
        temporal = 1'b0;
        case (kind)
            K_ONCE:
            begin
                temporal = 1'b1;
                if (r_op)
                begin
                    upd_bits = upd_bits | win_bits;
                    upd_tail = upd_tail | b_inf;
                end
            end
            K_HIST:
            begin
                temporal = 1'b1;
                if (!r_op)
                begin
                    upd_bits = upd_bits | win_bits;
                    upd_tail = upd_tail | b_inf;
                end
            end
            K_SINCE:
            begin
                temporal = 1'b1;
                if (l_op && r_op)
                begin
                    upd_bits = upd_bits | win_bits;
                    upd_tail = upd_tail | b_inf;
                end
                else if (r_op)
                begin
                    upd_bits = win_bits;
                    upd_tail = b_inf;
                end
                else if (!l_op)
                begin
                    upd_bits = '0;
                    upd_tail = 1'b0;
                end
            end
            default:
            begin
                temporal = 1'b0;
            end
        endcase
        // shift down one tick, top bit refilled from the tail
        ram_wdata = {upd_tail, upd_tail, upd_bits[HORIZON-1:1]};
    end

    // Node output
    always_comb
    begin
        node_upd = 1'b1;
        node_val = 1'b0;
        case (kind)
            K_PROP:    node_val = prop_reg[cur_reg];
            K_AND:     node_val = l_op && r_op;
            K_OR:      node_val = l_op || r_op;
            K_NOT:     node_val = !r_op;
            K_IMPLIES: node_val = !l_op || r_op;
            K_ONCE:    node_val = upd_bits[0];
            K_SINCE:   node_val = upd_bits[0];
            K_HIST:    node_val = !upd_bits[0];
            default:   node_upd = 1'b0;   // hold and unused codes keep the output
        endcase
    end

    assign ram_we = (state_reg == ST_RUN) && temporal;

    always_comb
    begin
        node_value_next = node_value_reg;
        if (state_reg == ST_RUN && node_upd)
        begin
            node_value_next[cur_reg] = node_val;
        end
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            last_reg        <= '0;
            prop_reg        <= '0;
            node_value_reg  <= '0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end
        else
        begin
            node_value_reg <= node_value_next;
            if (ram_we)
            begin
                entry_valid_reg[cur_reg] <= 1'b1;
            end
            // FLUSH loads the next word itself when the old one leaves
            if (m_valid_reg && m_tready && state_reg != ST_FLUSH)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        prop_reg  <= s_tdata;
                        cur_reg   <= '0;
                        last_reg  <= AW'(count_clamped - 4'd1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (cur_reg == last_reg || cur_reg == NODE_MAX)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{OUT_PAD{1'b0}}, NV_W'(node_value_reg),
                                        node_value_reg[last_reg]};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg     <= 4'd1;
            node_kinds_reg     <= '0;
            left_operands_reg  <= '0;
            right_operands_reg <= '0;
            lower_bounds_reg   <= '0;
            upper_bounds_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_COUNT:     node_count_reg     <= cfg_data[3:0];
                REG_NODE_KINDS:     node_kinds_reg     <= cfg_data[31:0];
                REG_LEFT_OPERANDS:  left_operands_reg  <= cfg_data[23:0];
                REG_RIGHT_OPERANDS: right_operands_reg <= cfg_data[23:0];
                REG_LOWER_BOUNDS:   lower_bounds_reg   <= cfg_data[63:0];
                REG_UPPER_BOUNDS:   upper_bounds_reg   <= cfg_data[63:0];
                default:            ;
            endcase
        end
    end

endmodule

/* rtl/ptm_ram.sv */
module ptm_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ptm_monitor_chk.sv */
module ptm_monitor_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ptm_pkg::OUT_W-1:0]       m_tdata
);

    import ptm_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // one tick in flight: no accept right after an accept
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick accepted while busy");

    // no result is raised straight after accepting a tick while no result is pending
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1:NV_W+1] == '0))
        else $error("result pad bits not zero");

endmodule

bind past_time_mtl_monitor_top ptm_monitor_chk u_ptm_monitor_chk (.*);
